>>> rtl/brtc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the boolean run-length range counter.
// No dependencies; every other file of the block but brtc_ifs.sv imports this package.
package brtc_pkg;

    // Field widths fixed by the column format
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned ROW_W  = 33;
    localparam int unsigned ADDR_W = 4;

    // Register reset values
    localparam logic [CNT_W-1:0] OFFSET_RST = '0;
    localparam logic [CNT_W-1:0] LENGTH_RST = CNT_W'(1);
    localparam logic             FIRST_RST  = 1'b0;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_RUN = 2'd1,
        ST_SHORT    = 2'd2,
        ST_ZERO_LEN = 2'd3
    } status_t;

    // Configuration register indexes (word address)
    typedef enum logic [1:0] {
        REG_OFFSET = 2'd0,
        REG_LENGTH = 2'd1,
        REG_FIRST  = 2'd2
    } reg_idx_t;

    // One run request
    typedef struct packed {
        logic [CNT_W-1:0] run_length;
        logic             last_run;
    } run_t;

    // One result
    typedef struct packed {
        logic [CNT_W-1:0] true_before;
        logic [CNT_W-1:0] true_in_range;
        status_t          status;
    } result_t;

    // Configuration as seen by the counting logic
    typedef struct packed {
        logic [CNT_W-1:0] range_offset;
        logic [CNT_W-1:0] range_length;
        logic             first_value;
        logic [ROW_W-1:0] range_end;
    } cfg_t;

endpackage

>>> rtl/brtc_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for run requests and result requests.
// Depends on nothing; field widths follow brtc_pkg.
interface brtc_run_if;
    logic        valid;
    logic        ready;
    logic [31:0] run_length;
    logic        last_run;

    modport source (output valid, run_length, last_run, input ready);
    modport sink   (input valid, run_length, last_run, output ready);
endinterface

interface brtc_cnt_if;
    logic        valid;
    logic        ready;
    logic [31:0] true_before;
    logic [31:0] true_in_range;
    logic [1:0]  status;

    modport source (output valid, true_before, true_in_range, status, input ready);
    modport sink   (input valid, true_before, true_in_range, status, output ready);
endinterface

>>> rtl/bool_rle_range_true_count.sv
`timescale 1ns / 1ps
// Boolean run-length range counter, top level.
// A run request waits in the input register; its result goes to the result register.
// Throughput: one run per cycle while no result stalls; the input and result registers
// decouple the two channels, and the per-run clip and add sits between them.
// Reset (rst_n, async, active low): registers to offset 0, length 1, first value 0;
// column state cleared, both channels empty.
module bool_rle_range_true_count (
    input  logic                        clk,
    input  logic                        rst_n,
    brtc_run_if.sink                    runs,
    brtc_cnt_if.source                  counts,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brtc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import brtc_pkg::*;

    cfg_t cfg;
    logic item_valid;
    logic take;
    run_t item;

    brtc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    brtc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .runs       (runs),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    brtc_count u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .counts     (counts)
    );

endmodule

>>> rtl/brtc_apb_regs.sv
`timescale 1ns / 1ps
// APB register file: range offset, range length, first run value.
// Depends on brtc_pkg. Also keeps offset + length precomputed as the range end.
module brtc_apb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [brtc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output brtc_pkg::cfg_t             cfg
);
    import brtc_pkg::*;

    logic [CNT_W-1:0] offset_reg, offset_next;
    logic [CNT_W-1:0] length_reg, length_next;
    logic             first_reg, first_next;
    logic [ROW_W-1:0] end_reg, end_next;
    logic             wr_en;
    reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    // Write decode; the range end follows whichever half changed
    always_comb
    begin
        offset_next = offset_reg;
        length_next = length_reg;
        first_next  = first_reg;
        if (wr_en)
        begin
            case (idx)
                REG_OFFSET: offset_next = pwdata;
                REG_LENGTH: length_next = pwdata;
                REG_FIRST:  first_next  = pwdata[0];
                default:    ;
            endcase
        end
        end_next = {1'b0, offset_next} + {1'b0, length_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RST;
            length_reg <= LENGTH_RST;
            first_reg  <= FIRST_RST;
            end_reg    <= {1'b0, OFFSET_RST} + {1'b0, LENGTH_RST};
        end
        else
        begin
            offset_reg <= offset_next;
            length_reg <= length_next;
            first_reg  <= first_next;
            end_reg    <= end_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_OFFSET: prdata = offset_reg;
            REG_LENGTH: prdata = length_reg;
            REG_FIRST:  prdata = {31'd0, first_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.range_offset = offset_reg;
    assign cfg.range_length = length_reg;
    assign cfg.first_value  = first_reg;
    assign cfg.range_end    = end_reg;

endmodule

>>> rtl/brtc_in_stage.sv
`timescale 1ns / 1ps
// Input register for run requests; frees itself as soon as the counter takes it.
// Depends on brtc_pkg and brtc_run_if.
module brtc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    brtc_run_if.sink       runs,
    input  logic           take,
    output logic           item_valid,
    output brtc_pkg::run_t item
);
    import brtc_pkg::*;

    logic valid_reg, valid_next;
    run_t item_reg;
    logic accept;

    assign runs.ready = !valid_reg || take;
    assign accept     = runs.valid && runs.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.run_length <= runs.run_length;
            item_reg.last_run   <= runs.last_run;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/brtc_count.sv
`timescale 1ns / 1ps
// Per-run clip and count: column state, range clipping and the result register.
// Depends on brtc_pkg and brtc_cnt_if.
module brtc_count (
    input  logic           clk,
    input  logic           rst_n,
    input  brtc_pkg::cfg_t cfg,
    input  logic           item_valid,
    input  brtc_pkg::run_t item,
    output logic           take,
    brtc_cnt_if.source     counts
);
    import brtc_pkg::*;

    localparam int unsigned POS_W = ROW_W + 1;

    // Column state
    logic [ROW_W-1:0] row_reg, row_next;
    logic             cur_reg, cur_next;
    logic [CNT_W-1:0] before_reg, before_next;
    logic [CNT_W-1:0] range_reg, range_next;
    logic             fin_reg, fin_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg, res_next;

    logic             out_free;
    logic             val;
    logic [POS_W-1:0] start, stop, off, rend, lim, lo, hi, bdiff, rdiff;
    logic [CNT_W-1:0] before_sum, range_sum;

    assign out_free = !out_valid_reg || counts.ready;
    assign take     = item_valid && out_free;

    // Run clipping against [offset, end)
    always_comb
    begin
        val   = (row_reg == '0) ? cfg.first_value : cur_reg;
        start = {1'b0, row_reg};
        stop  = start + {2'b0, item.run_length};
        off   = {2'b0, cfg.range_offset};
        rend  = {1'b0, cfg.range_end};
        lim   = (stop < off) ? stop : off;
        bdiff = lim - start;
        lo    = (start > off) ? start : off;
        hi    = (stop < rend) ? stop : rend;
        rdiff = hi - lo;
        before_sum = before_reg;
        range_sum  = range_reg;
        if (val && (start < off))
            before_sum = before_reg + bdiff[CNT_W-1:0];
        if (val && (lo < hi))
            range_sum = range_reg + rdiff[CNT_W-1:0];
    end

    // State update and result selection
    always_comb
    begin
        row_next       = row_reg;
        cur_next       = cur_reg;
        before_next    = before_reg;
        range_next     = range_reg;
        fin_next       = fin_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !counts.ready;
        if (take)
        begin
            if (!fin_reg)
            begin
                cur_next = val;
                if (cfg.range_length == '0)
                begin
                    res_next       = '{'0, '0, ST_ZERO_LEN};
                    out_valid_next = 1'b1;
                    fin_next       = 1'b1;
                end
                else if (item.run_length == '0)
                begin
                    res_next       = '{'0, '0, ST_ZERO_RUN};
                    out_valid_next = 1'b1;
                    fin_next       = 1'b1;
                end
                else
                begin
                    before_next = before_sum;
                    range_next  = range_sum;
                    if (stop >= rend)
                    begin
                        res_next       = '{before_sum, range_sum, ST_OK};
                        out_valid_next = 1'b1;
                        fin_next       = 1'b1;
                        row_next       = cfg.range_end;
                    end
                    else
                    begin
                        row_next = stop[ROW_W-1:0];
                        cur_next = !val;
                        if (item.last_run)
                        begin
                            res_next       = '{'0, '0, ST_SHORT};
                            out_valid_next = 1'b1;
                            fin_next       = 1'b1;
                        end
                    end
                end
            end
            // Last run rearms the column
            if (item.last_run)
            begin
                row_next    = '0;
                cur_next    = cfg.first_value;
                before_next = '0;
                range_next  = '0;
                fin_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            cur_reg       <= FIRST_RST;
            before_reg    <= '0;
            range_reg     <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            cur_reg       <= cur_next;
            before_reg    <= before_next;
            range_reg     <= range_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign counts.valid         = out_valid_reg;
    assign counts.true_before   = res_reg.true_before;
    assign counts.true_in_range = res_reg.true_in_range;
    assign counts.status        = res_reg.status;

endmodule

>>> rtl/brtc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the range counter, bound to the top level.
// Depends on brtc_pkg and the top level's ports.
module brtc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] true_before,
    input logic [31:0] true_in_range,
    input logic [1:0]  status,
    input logic        pready
);
    import brtc_pkg::*;

    // Error results carry no counts
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> ((true_before == '0) && (true_in_range == '0)))
        else $error("error result with nonzero counts");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(true_before) && $stable(true_in_range) && $stable(status)))
        else $error("stalled result changed");

    // A new result appears only after an accepted run request
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching run request");

    // Register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind bool_rle_range_true_count brtc_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (runs.valid),
    .in_ready      (runs.ready),
    .out_valid     (counts.valid),
    .out_ready     (counts.ready),
    .true_before   (counts.true_before),
    .true_in_range (counts.true_in_range),
    .status        (counts.status),
    .pready        (pready)
);
